// File: design/bdf_pkg.sv
// Shared types and constants for the variable-step BDF coefficient unit.
// Used by bdf_alu, bdf_variable_step_coefficients and the testbench files; no dependencies.
package bdf_pkg;

  localparam int MAX_ORDER_DEF  = 6;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  localparam int IN_W        = 32;  // sample_time field
  localparam int IDX_W       = 3;   // coef_index field
  localparam int COEF_W      = 32;  // a and b coefficient fields
  localparam int QUO_W       = 34;  // quotient bits kept before saturation
  localparam int OUT_TDATA_W = 72;  // index + a + b, padded to bytes

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_ADD,
    ALU_SUB,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
  } alu_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_J_RD,
    ST_J_LD,
    ST_LP_RD,
    ST_LP_WAIT,
    ST_LP_MUL,
    ST_LP_END,
    ST_ACC,
    ST_SFIX,
    ST_SCHK,
    ST_BMUL,
    ST_BWAIT,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_EQ,
    PH_P,
    PH_S,
    PH_NUM,
    PH_DEN,
    PH_B
  } phase_t;

endpackage

// File: design/bdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 7
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bdf_alu.sv
// Shared wide arithmetic unit: shift-add multiply (big x stamp), add, subtract
// and restoring division with rounding and saturation to Q format.
// Depends on bdf_pkg.
module bdf_alu #(
  parameter int TIME_WIDTH = bdf_pkg::TIME_WIDTH_DEF,
  parameter int BIG_W      = 2 * bdf_pkg::MAX_ORDER_DEF * bdf_pkg::TIME_WIDTH_DEF + 4,
  parameter int FRAC_BITS  = bdf_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bdf_pkg::alu_ctl_t         ctl,
  input  logic [BIG_W-1:0]          x,
  input  logic [BIG_W-1:0]          y,
  input  logic [TIME_WIDTH-1:0]     mult,
  input  logic                      div_neg,
  output bdf_pkg::alu_sts_t         sts,
  output logic [BIG_W-1:0]          res,
  output logic [bdf_pkg::COEF_W-1:0] quo
);

  localparam int AW    = BIG_W + 1;
  localparam int NSH_W = BIG_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NSH_W + 1);
  localparam int QW    = bdf_pkg::QUO_W;
  localparam int CW    = bdf_pkg::COEF_W;
  localparam logic [QW:0]   LIM_NEG = (QW + 1)'(1) << (CW - 1);
  localparam logic [QW:0]   LIM_POS = LIM_NEG - (QW + 1)'(1);
  localparam logic [CW-1:0] SAT_MIN = CW'(1) << (CW - 1);
  localparam logic [CW-1:0] SAT_MAX = SAT_MIN - CW'(1);

  logic                busy;
  logic                done;
  bdf_pkg::alu_op_t    op;
  logic [CNT_W-1:0]    cnt;
  logic [BIG_W-1:0]    acc;
  logic [BIG_W-1:0]    mc;
  logic [TIME_WIDTH-1:0] ml;
  logic [BIG_W-1:0]    rem;
  logic [NSH_W-1:0]    nsh;
  logic [QW-1:0]       q;
  logic                huge;
  logic                neg;

  logic [AW-1:0] add_a;
  logic [AW-1:0] add_b;
  logic          add_sub;
  logic [AW:0]   add_sum;
  logic          carry;
  logic [QW:0]   qr;
  logic [CW-1:0] sat;

  // one shared adder; subtract is add of complement plus one
  always_comb begin
    add_a   = {1'b0, x};
    add_b   = {1'b0, y};
    add_sub = 1'b0;
    if (ctl.start) begin
      add_sub = (ctl.op == bdf_pkg::ALU_SUB);
    end else if (op == bdf_pkg::ALU_MUL) begin
      add_a = {1'b0, acc[BIG_W-2:0], 1'b0};
      add_b = ml[TIME_WIDTH-1] ? {1'b0, mc} : '0;
    end else begin
      add_a   = (cnt != '0) ? {rem, nsh[NSH_W-1]} : {rem, 1'b0};
      add_b   = {1'b0, mc};
      add_sub = 1'b1;
    end
    add_sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b} + (AW + 1)'(add_sub);
    carry   = add_sum[AW];
  end

  // round half away from zero (carry = 2*rem >= den), then saturate
  always_comb begin
    qr = {1'b0, q} + (QW + 1)'(carry);
    if (neg) begin
      sat = (huge || qr > LIM_NEG) ? SAT_MIN : CW'(0) - qr[CW-1:0];
    end else begin
      sat = (huge || qr > LIM_POS) ? SAT_MAX : qr[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= (ctl.op == bdf_pkg::ALU_MUL) || (ctl.op == bdf_pkg::ALU_DIV);
        done <= (ctl.op == bdf_pkg::ALU_ADD) || (ctl.op == bdf_pkg::ALU_SUB);
      end else if (busy) begin
        case (op)
          bdf_pkg::ALU_MUL: begin
            if (cnt == CNT_W'(1)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          bdf_pkg::ALU_DIV: begin
            if (cnt == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op  <= ctl.op;
      neg <= div_neg;
      case (ctl.op)
        bdf_pkg::ALU_MUL: begin
          acc <= '0;
          mc  <= y;
          ml  <= mult;
          cnt <= CNT_W'(TIME_WIDTH);
        end
        bdf_pkg::ALU_DIV: begin
          rem  <= '0;
          nsh  <= {x, {FRAC_BITS{1'b0}}};
          mc   <= y;
          q    <= '0;
          huge <= 1'b0;
          cnt  <= CNT_W'(NSH_W);
        end
        default: begin
          acc <= add_sum[BIG_W-1:0];
        end
      endcase
    end else if (busy) begin
      case (op)
        bdf_pkg::ALU_MUL: begin
          acc <= add_sum[BIG_W-1:0];
          ml  <= ml << 1;
          cnt <= cnt - CNT_W'(1);
        end
        bdf_pkg::ALU_DIV: begin
          if (cnt != '0) begin
            rem  <= carry ? add_sum[BIG_W-1:0] : add_a[BIG_W-1:0];
            q    <= {q[QW-2:0], carry};
            huge <= huge | q[QW-1];
            nsh  <= nsh << 1;
            cnt  <= cnt - CNT_W'(1);
          end else begin
            quo <= sat;
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign sts.done = done;
  assign res      = acc;

endmodule

// File: design/bdf_variable_step_coefficients.sv
// Flow: a stamp without the last flag is accepted and the unit stays idle. A run of order n takes
//   3n^2-n+1 shift-add multiplies and n+1 divisions in the shared arithmetic unit,
//   plus stamp compares and result handshakes.
// Throughput: one run at a time; s_axis_tready is high only while idle.
// Reset (rst, synchronous): clears the stamp count, sequencer and output valid.
// Depends on bdf_pkg, bdf_ram, bdf_alu.
module bdf_variable_step_coefficients #(
  parameter int MAX_ORDER  = bdf_pkg::MAX_ORDER_DEF,
  parameter int TIME_WIDTH = bdf_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = bdf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bdf_pkg::IN_W-1:0]        s_axis_tdata,  // [31:0] sample_time
  input  logic                            s_axis_tlast,  // last_sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] coef_index, [34:3] a_coefficient, [66:35] b_coefficient, [71:67] zero
  output logic [bdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,  // error_flag
  output logic                            m_axis_tlast   // last_coef
);

  localparam int NSTAMP = MAX_ORDER + 1;
  localparam int BIG_W  = 2 * MAX_ORDER * TIME_WIDTH + 4;
  localparam int CNT_W  = $clog2(NSTAMP + 2);
  localparam int IW     = $clog2(NSTAMP + 1);
  localparam int RAW    = $clog2(NSTAMP);
  localparam int CW     = bdf_pkg::COEF_W;
  localparam logic [CW-1:0]    ONE_Q  = CW'(1) << FRAC_BITS;
  localparam logic [IW-1:0]    NONE   = IW'(NSTAMP);
  localparam logic [BIG_W-1:0] BIG_1  = BIG_W'(1);

  bdf_pkg::state_t state, state_next;
  bdf_pkg::phase_t phase, phase_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [TIME_WIDTH-1:0] tnew, tnew_next, tprev, tprev_next, treg, treg_next;
  logic [IW-1:0]         n, n_next, j, j_next, m, m_next, mlim, mlim_next, skip, skip_next;
  logic [BIG_W-1:0]      cur, cur_next, pbig, pbig_next, sbig, sbig_next, num, num_next;
  logic                  lsg, lsg_next, pneg, pneg_next, sneg, sneg_next;
  logic                  ovalid, ovalid_next;
  logic [bdf_pkg::IDX_W-1:0] o_idx, o_idx_next;
  logic [CW-1:0]         o_a, o_a_next, o_b, o_b_next;
  logic                  o_err, o_err_next, o_last, o_last_next;

  logic                  in_acc;
  logic [TIME_WIDTH-1:0] tin;
  logic                  ram_we;
  logic [RAW-1:0]        ram_raddr;
  logic [TIME_WIDTH-1:0] rdata;
  logic [TIME_WIDTH-1:0] base;
  logic [TIME_WIDTH-1:0] dmag;
  logic                  dneg;
  logic [TIME_WIDTH-1:0] bmag;
  logic                  bneg;
  logic [IW-1:0]         j_inc;

  bdf_pkg::alu_ctl_t     alu_ctl;
  bdf_pkg::alu_sts_t     alu_sts;
  logic [BIG_W-1:0]      alu_x, alu_y, alu_res;
  logic [TIME_WIDTH-1:0] alu_mult;
  logic                  alu_neg;
  logic [CW-1:0]         alu_quo;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign tin    = TIME_WIDTH'(s_axis_tdata);
  assign ram_we = in_acc && (count < CNT_W'(NSTAMP));

  bdf_ram #(
    .WIDTH (TIME_WIDTH),
    .DEPTH (NSTAMP)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[RAW-1:0]),
    .wdata (tin),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  bdf_alu #(
    .TIME_WIDTH (TIME_WIDTH),
    .BIG_W      (BIG_W),
    .FRAC_BITS  (FRAC_BITS)
  ) u_alu (
    .clk     (clk),
    .rst     (rst),
    .ctl     (alu_ctl),
    .x       (alu_x),
    .y       (alu_y),
    .mult    (alu_mult),
    .div_neg (alu_neg),
    .sts     (alu_sts),
    .res     (alu_res),
    .quo     (alu_quo)
  );

  // signed stamp differences as magnitude and sign
  always_comb begin
    base  = (phase == bdf_pkg::PH_EQ || phase == bdf_pkg::PH_DEN) ? treg : tnew;
    dneg  = base < rdata;
    dmag  = dneg ? rdata - base : base - rdata;
    bneg  = tnew < tprev;
    bmag  = bneg ? tprev - tnew : tnew - tprev;
    j_inc = j + IW'(1);
  end

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    count_next  = count;
    tnew_next   = tnew;
    tprev_next  = tprev;
    treg_next   = treg;
    n_next      = n;
    j_next      = j;
    m_next      = m;
    mlim_next   = mlim;
    skip_next   = skip;
    cur_next    = cur;
    lsg_next    = lsg;
    pbig_next   = pbig;
    pneg_next   = pneg;
    sbig_next   = sbig;
    sneg_next   = sneg;
    num_next    = num;
    ovalid_next = ovalid;
    o_idx_next  = o_idx;
    o_a_next    = o_a;
    o_b_next    = o_b;
    o_err_next  = o_err;
    o_last_next = o_last;
    alu_ctl     = '{start: 1'b0, op: bdf_pkg::ALU_ADD};
    alu_x       = '0;
    alu_y       = cur;
    alu_mult    = dmag;
    alu_neg     = lsg;
    ram_raddr   = m[RAW-1:0];
    s_axis_tready = (state == bdf_pkg::ST_IDLE);

    case (state)
      bdf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (count < CNT_W'(NSTAMP)) begin
            tprev_next = tnew;
            tnew_next  = tin;
          end
          if (!s_axis_tlast) begin
            if (count < CNT_W'(NSTAMP + 1)) begin
              count_next = count + CNT_W'(1);
            end
          end else begin
            count_next = '0;
            if (count == '0 || count >= CNT_W'(NSTAMP)) begin
              o_idx_next  = '0;
              o_a_next    = '0;
              o_b_next    = '0;
              o_err_next  = 1'b1;
              o_last_next = 1'b1;
              ovalid_next = 1'b1;
              state_next  = bdf_pkg::ST_EMIT;
            end else begin
              n_next     = IW'(count);
              j_next     = '0;
              phase_next = bdf_pkg::PH_EQ;
              state_next = bdf_pkg::ST_J_RD;
            end
          end
        end
      end

      bdf_pkg::ST_J_RD: begin
        ram_raddr  = j[RAW-1:0];
        state_next = bdf_pkg::ST_J_LD;
      end

      bdf_pkg::ST_J_LD: begin
        treg_next = rdata;
        mlim_next = n;
        if (phase == bdf_pkg::PH_EQ) begin
          m_next    = j_inc;
          skip_next = NONE;
        end else begin
          m_next    = '0;
          skip_next = j;
          cur_next  = sbig;
        end
        state_next = bdf_pkg::ST_LP_RD;
      end

      bdf_pkg::ST_LP_RD: begin
        if (m > mlim) begin
          state_next = bdf_pkg::ST_LP_END;
        end else if (m == skip) begin
          m_next = m + IW'(1);
        end else begin
          state_next = bdf_pkg::ST_LP_WAIT;
        end
      end

      bdf_pkg::ST_LP_WAIT: begin
        if (phase == bdf_pkg::PH_EQ) begin
          m_next = m + IW'(1);
          if (rdata == treg) begin
            o_idx_next  = '0;
            o_a_next    = '0;
            o_b_next    = '0;
            o_err_next  = 1'b1;
            o_last_next = 1'b1;
            ovalid_next = 1'b1;
            state_next  = bdf_pkg::ST_EMIT;
          end else begin
            state_next = bdf_pkg::ST_LP_RD;
          end
        end else begin
          alu_ctl    = '{start: 1'b1, op: bdf_pkg::ALU_MUL};
          lsg_next   = lsg ^ dneg;
          state_next = bdf_pkg::ST_LP_MUL;
        end
      end

      bdf_pkg::ST_LP_MUL: begin
        if (alu_sts.done) begin
          cur_next   = alu_res;
          m_next     = m + IW'(1);
          state_next = bdf_pkg::ST_LP_RD;
        end
      end

      bdf_pkg::ST_LP_END: begin
        case (phase)
          bdf_pkg::PH_EQ: begin
            j_next = j_inc;
            if (j_inc == n) begin
              phase_next = bdf_pkg::PH_P;
              cur_next   = BIG_1;
              lsg_next   = 1'b0;
              m_next     = '0;
              mlim_next  = n - IW'(1);
              skip_next  = NONE;
              state_next = bdf_pkg::ST_LP_RD;
            end else begin
              state_next = bdf_pkg::ST_J_RD;
            end
          end
          bdf_pkg::PH_P: begin
            pbig_next  = cur;
            pneg_next  = lsg;
            sbig_next  = '0;
            j_next     = '0;
            phase_next = bdf_pkg::PH_S;
            cur_next   = BIG_1;
            lsg_next   = 1'b0;
            m_next     = '0;
            skip_next  = '0;
            state_next = bdf_pkg::ST_LP_RD;
          end
          bdf_pkg::PH_S: begin
            // signed running sum of the partial products
            alu_ctl    = '{start: 1'b1, op: lsg ? bdf_pkg::ALU_SUB : bdf_pkg::ALU_ADD};
            alu_x      = sbig;
            state_next = bdf_pkg::ST_ACC;
          end
          bdf_pkg::PH_NUM: begin
            num_next   = cur;
            phase_next = bdf_pkg::PH_DEN;
            state_next = bdf_pkg::ST_J_RD;
          end
          default: begin
            alu_ctl    = '{start: 1'b1, op: bdf_pkg::ALU_DIV};
            alu_x      = num;
            state_next = bdf_pkg::ST_DIV;
          end
        endcase
      end

      bdf_pkg::ST_ACC: begin
        if (alu_sts.done) begin
          sbig_next = alu_res;
          j_next    = j_inc;
          if (j_inc == n) begin
            state_next = bdf_pkg::ST_SFIX;
          end else begin
            cur_next   = BIG_1;
            lsg_next   = 1'b0;
            m_next     = '0;
            skip_next  = j_inc;
            state_next = bdf_pkg::ST_LP_RD;
          end
        end
      end

      bdf_pkg::ST_SFIX: begin
        sneg_next  = sbig[BIG_W-1];
        alu_ctl    = '{start: 1'b1,
                       op: sbig[BIG_W-1] ? bdf_pkg::ALU_SUB : bdf_pkg::ALU_ADD};
        alu_y      = sbig;
        state_next = bdf_pkg::ST_SCHK;
      end

      bdf_pkg::ST_SCHK: begin
        if (alu_sts.done) begin
          sbig_next = alu_res;
          if (alu_res == '0) begin
            o_idx_next  = '0;
            o_a_next    = '0;
            o_b_next    = '0;
            o_err_next  = 1'b1;
            o_last_next = 1'b1;
            ovalid_next = 1'b1;
            state_next  = bdf_pkg::ST_EMIT;
          end else begin
            j_next     = '0;
            phase_next = bdf_pkg::PH_NUM;
            cur_next   = pbig;
            lsg_next   = pneg ^ sbig[BIG_W-1];
            m_next     = '0;
            mlim_next  = n - IW'(1);
            skip_next  = '0;
            state_next = bdf_pkg::ST_LP_RD;
          end
        end
      end

      bdf_pkg::ST_BMUL: begin
        alu_ctl    = '{start: 1'b1, op: bdf_pkg::ALU_MUL};
        alu_y      = sbig;
        alu_mult   = bmag;
        lsg_next   = pneg ^ sneg ^ bneg;
        phase_next = bdf_pkg::PH_B;
        state_next = bdf_pkg::ST_BWAIT;
      end

      bdf_pkg::ST_BWAIT: begin
        if (alu_sts.done) begin
          alu_ctl    = '{start: 1'b1, op: bdf_pkg::ALU_DIV};
          alu_x      = pbig;
          alu_y      = alu_res;
          state_next = bdf_pkg::ST_DIV;
        end
      end

      bdf_pkg::ST_DIV: begin
        if (alu_sts.done) begin
          o_err_next  = 1'b0;
          ovalid_next = 1'b1;
          state_next  = bdf_pkg::ST_EMIT;
          if (phase == bdf_pkg::PH_B) begin
            o_idx_next  = bdf_pkg::IDX_W'(n);
            o_a_next    = ONE_Q;
            o_b_next    = alu_quo;
            o_last_next = 1'b1;
          end else begin
            o_idx_next  = bdf_pkg::IDX_W'(j);
            o_a_next    = alu_quo;
            o_b_next    = '0;
            o_last_next = 1'b0;
          end
        end
      end

      bdf_pkg::ST_EMIT: begin
        if (m_axis_tready) begin
          ovalid_next = 1'b0;
          if (o_last) begin
            state_next = bdf_pkg::ST_IDLE;
          end else begin
            j_next = j_inc;
            if (j_inc == n) begin
              state_next = bdf_pkg::ST_BMUL;
            end else begin
              phase_next = bdf_pkg::PH_NUM;
              cur_next   = pbig;
              lsg_next   = pneg ^ sneg;
              m_next     = '0;
              mlim_next  = n - IW'(1);
              skip_next  = j_inc;
              state_next = bdf_pkg::ST_LP_RD;
            end
          end
        end
      end

      default: begin
        state_next = bdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bdf_pkg::ST_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    phase  <= phase_next;
    tnew   <= tnew_next;
    tprev  <= tprev_next;
    treg   <= treg_next;
    n      <= n_next;
    j      <= j_next;
    m      <= m_next;
    mlim   <= mlim_next;
    skip   <= skip_next;
    cur    <= cur_next;
    lsg    <= lsg_next;
    pbig   <= pbig_next;
    pneg   <= pneg_next;
    sbig   <= sbig_next;
    sneg   <= sneg_next;
    num    <= num_next;
    o_idx  <= o_idx_next;
    o_a    <= o_a_next;
    o_b    <= o_b_next;
    o_err  <= o_err_next;
    o_last <= o_last_next;
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = {(bdf_pkg::OUT_TDATA_W - 2 * CW - bdf_pkg::IDX_W)'(0), o_b, o_a, o_idx};
  assign m_axis_tuser  = o_err;
  assign m_axis_tlast  = o_last;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result carries nonzero data");
`endif

endmodule

// File: tb/bdf_coef_checker.sv
// Watches both stream channels of the BDF coefficient unit, predicts the coefficient
// pairs of every run with exact wide-integer arithmetic, and compares each result item.
// Depends on bdf_pkg for field widths.
module bdf_coef_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [bdf_pkg::IN_W-1:0]        s_axis_tdata,   // [31:0] sample_time
  input  logic                            s_axis_tlast,   // last_sample
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] coef_index, [34:3] a_coefficient, [66:35] b_coefficient, [71:67] zero
  input  logic [bdf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tuser,   // error_flag
  input  logic                            m_axis_tlast,   // last_coef
  output int                              fail_count,
  output int                              coef_pending
);
  import bdf_pkg::*;

  localparam int NSTAMP = MAX_ORDER_DEF + 1;
  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int WB     = 640;

  typedef logic [WB-1:0] wide_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic              err;
    logic              last;
  } coef_t;

  coef_t       coef_q[$];
  logic [31:0] stamps[NSTAMP];
  int          stamp_cnt;

  assign coef_pending = coef_q.size();

  function automatic logic [31:0] gap_mag(logic [31:0] x, logic [31:0] y);
    return (x >= y) ? x - y : y - x;
  endfunction

  // round-half-away, sign applied after, saturated to 32 bits
  function automatic logic [31:0] to_q(wide_t num, wide_t den, bit neg);
    wide_t q, r;
    q = (num << FRAC) / den;
    r = (num << FRAC) % den;
    if ((r << 1) >= den) q = q + 1;
    if (neg) begin
      if (q > wide_t'(32'h8000_0000)) return 32'h8000_0000;
      return 32'h0 - q[31:0];
    end
    if (q > wide_t'(32'h7FFF_FFFF)) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic void push_error();
    coef_t e;
    e.idx = '0; e.a = '0; e.b = '0; e.err = 1'b1; e.last = 1'b1;
    coef_q.push_back(e);
  endfunction

  function automatic void predict_run(int total);
    int    n;
    bit    pneg, sneg, tn, sg, dneg;
    wide_t prod_p, pos, ngs, sum_s, term, num, den;
    coef_t e;
    if (total < 2 || total > NSTAMP) begin
      push_error();
      return;
    end
    n = total - 1;
    for (int j = 0; j <= n; j++)
      for (int k = j + 1; k <= n; k++)
        if (stamps[j] == stamps[k]) begin
          push_error();
          return;
        end
    prod_p = 1;
    pneg = 0;
    for (int m = 0; m < n; m++) begin
      pneg ^= stamps[n] < stamps[m];
      prod_p = prod_p * gap_mag(stamps[n], stamps[m]);
    end
    pos = 0;
    ngs = 0;
    for (int m = 0; m < n; m++) begin
      tn = 0;
      term = 1;
      for (int k = 0; k < n; k++) begin
        if (k == m) continue;
        tn ^= stamps[n] < stamps[k];
        term = term * gap_mag(stamps[n], stamps[k]);
      end
      if (tn) ngs = ngs + term;
      else pos = pos + term;
    end
    sneg = pos < ngs;
    sum_s = sneg ? ngs - pos : pos - ngs;
    if (sum_s == 0) begin
      push_error();
      return;
    end
    for (int j = 0; j < n; j++) begin
      sg = pneg ^ sneg;
      num = 1;
      den = 1;
      for (int m = 0; m < n; m++) begin
        if (m == j) continue;
        sg ^= stamps[n] < stamps[m];
        num = num * gap_mag(stamps[n], stamps[m]);
      end
      num = num * prod_p;
      for (int m = 0; m <= n; m++) begin
        if (m == j) continue;
        sg ^= stamps[j] < stamps[m];
        den = den * gap_mag(stamps[j], stamps[m]);
      end
      den = den * sum_s;
      e.idx = j[IDX_W-1:0]; e.a = to_q(num, den, sg); e.b = '0; e.err = 0; e.last = 0;
      coef_q.push_back(e);
    end
    dneg = stamps[n] < stamps[n-1];
    den = wide_t'(gap_mag(stamps[n], stamps[n-1])) * sum_s;
    e.idx = n[IDX_W-1:0];
    e.a = 32'(1) << FRAC;
    e.b = to_q(prod_p, den, pneg ^ sneg ^ dneg);
    e.err = 0;
    e.last = 1;
    coef_q.push_back(e);
  endfunction

  always @(posedge clk) begin
    coef_t got, want;
    if (rst) begin
      stamp_cnt  <= 0;
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (stamp_cnt < NSTAMP) stamps[stamp_cnt] = s_axis_tdata;
        if (s_axis_tlast) begin
          predict_run(stamp_cnt < NSTAMP + 1 ? stamp_cnt + 1 : stamp_cnt);
          stamp_cnt <= 0;
        end else if (stamp_cnt < NSTAMP + 1) begin
          stamp_cnt <= stamp_cnt + 1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx  = m_axis_tdata[2:0];
        got.a    = m_axis_tdata[34:3];
        got.b    = m_axis_tdata[66:35];
        got.err  = m_axis_tuser;
        got.last = m_axis_tlast;
        if (coef_q.size() == 0) begin
          $display("%0t: unexpected item idx=%0d a=%h b=%h err=%b last=%b", $time,
                   got.idx, got.a, got.b, got.err, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = coef_q.pop_front();
          if (got.idx !== want.idx || got.a !== want.a || got.b !== want.b ||
              got.err !== want.err || got.last !== want.last) begin
            $display("%0t: expected idx=%0d a=%h b=%h err=%b last=%b", $time,
                     want.idx, want.a, want.b, want.err, want.last);
            $display("%0t:   actual idx=%0d a=%h b=%h err=%b last=%b", $time,
                     got.idx, got.a, got.b, got.err, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/bdf_variable_step_coefficients_tb.sv
// Stimulus and verdict for the variable-step BDF coefficient unit: directed runs, then
// random stamp runs with random idling on both channels. Depends on bdf_pkg, bdf_coef_checker.
module bdf_variable_step_coefficients_tb;
  import bdf_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;
  int                     fail_count;
  int                     coef_pending;
  int                     items_sent = 0;
  bit                     steady = 0;
  bit                     drained_once = 0;
  int                     stall_left = 0;

  always #1 clk = ~clk;

  bdf_variable_step_coefficients dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  bdf_coef_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .fail_count(fail_count), .coef_pending(coef_pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  task automatic send_stamp(logic [31:0] t, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // one run of order n; style picks the spacing of the stamps
  task automatic send_run(int n, int style);
    logic [31:0] t, step;
    t = $urandom;
    for (int i = 0; i <= n; i++) begin
      send_stamp(t, i == n);
      case (style)
        0: step = $urandom_range(1, 255);
        1: step = $urandom;
        2: step = (i == n - 1) ? $urandom_range(1, 4) : $urandom_range(1 << 16, 1 << 26);
        default: step = $urandom;  // fully unordered stamps
      endcase
      t = (style == 3) ? step : t + step;
    end
  endtask

  // stop offering items, let the checker see the last accept, then wait for the results
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    @(posedge clk);
    while (coef_pending != 0) @(posedge clk);
  endtask

  initial begin
    int kind;
    int cnt;
    logic [31:0] t;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest order, extremes of the stamp, wrapped difference
    send_stamp(32'h0, 1'b0);          send_stamp(32'h1, 1'b1);
    send_stamp(32'hFFFF_FFFF, 1'b0);  send_stamp(32'h0, 1'b1);
    // lone flagged stamp: too few
    send_stamp(32'h1234_5678, 1'b1);
    // equal stamps
    send_stamp(32'd5, 1'b0);          send_stamp(32'd5, 1'b1);
    // the signed sum term vanishes (error run): newest stamp midway between the others
    send_stamp(32'd0, 1'b0); send_stamp(32'd10, 1'b0); send_stamp(32'd5, 1'b1);
    // full order, even spacing
    for (int i = 0; i <= 6; i++) send_stamp(32'(i * 100), i == 6);
    // one stamp too many
    for (int i = 0; i < 8; i++) send_stamp(32'(i * 7 + 3), i == 7);
    wait_drained();

    while (items_sent < 225) begin
      if ($urandom_range(0, 9) == 0) steady = ~steady;
      if (!drained_once && items_sent > 110) begin
        wait_drained();  // hold off until drained
        drained_once = 1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        send_run($urandom_range(1, 6), $urandom_range(0, 3));
      end else if (kind < 85) begin
        send_stamp($urandom, 1'b1);
      end else if (kind < 92) begin
        cnt = $urandom_range(8, 11);
        for (int i = 0; i < cnt; i++) send_stamp($urandom, i == cnt - 1);
      end else begin
        cnt = $urandom_range(2, 7);
        t = $urandom;
        for (int i = 0; i < cnt; i++)
          send_stamp((i == cnt - 1) ? t : t + 32'(i * 3 + 1), i == cnt - 1);
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && coef_pending == 0) begin
      $display("bdf_variable_step_coefficients: match");
    end else begin
      $display("bdf_variable_step_coefficients: mismatch");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("bdf_variable_step_coefficients: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
design/bdf_pkg.sv
design/bdf_ram.sv
design/bdf_alu.sv
design/bdf_variable_step_coefficients.sv
tb/bdf_coef_checker.sv
tb/bdf_variable_step_coefficients_tb.sv
